FILE: rtl/core/rip_route_table_update_defines.svh
// assertion macros for the route table update block
// no dependencies; included by the checker
`ifndef RIP_ROUTE_TABLE_UPDATE_DEFINES_SVH
`define RIP_ROUTE_TABLE_UPDATE_DEFINES_SVH
// assert a property on the rising clock edge, quiet during reset
`define RRTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assert a property that also holds while reset is high
`define RRTU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: rtl/core/rrtu_pkg.sv
// shared types and constants for the route table update block
// no dependencies
package rrtu_pkg;
  localparam int TableDepth = 1024;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam logic [4:0] MetricInf = 5'd16;

  localparam logic [2:0] ACT_KEPT     = 3'd0;
  localparam logic [2:0] ACT_UPDATED  = 3'd1;
  localparam logic [2:0] ACT_REMOVED  = 3'd2;
  localparam logic [2:0] ACT_INSERTED = 3'd3;
  localparam logic [2:0] ACT_IGNORED  = 3'd4;
  localparam logic [2:0] ACT_FULL     = 3'd5;

  typedef struct packed {
    logic [1:0]  in_port;
    logic [31:0] neighbour_addr;
    logic [31:0] route_prefix;
    logic [31:0] route_mask;
    logic [31:0] advertised_hop;
    logic [7:0]  advertised_metric;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  entry_index;
    logic [10:0] entry_count;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  port;
    logic [31:0] neighbour;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [4:0]  metric;
    logic [31:0] now;
  } cmd_t;

  // one table row
  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [1:0]  port;
    logic [4:0]  metric;
    logic [31:0] stamp;
    logic [31:0] origin;
  } row_t;
endpackage

FILE: rtl/core/rrtu_front.sv
// front part: takes route entries, saturates the metric, fills in the next hop
// and queues the command; depends on rrtu_pkg
module rrtu_front import rrtu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);
  // two-entry queue
  cmd_t q [2];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  cmd_t c;
  logic [8:0] m1;

  always_comb begin
    m1 = {1'b0, in_data.advertised_metric} + 9'd1;
    c.port = in_data.in_port;
    c.neighbour = in_data.neighbour_addr;
    c.prefix = in_data.route_prefix;
    c.mask = in_data.route_mask;
    c.hop = (in_data.advertised_hop == '0) ? in_data.neighbour_addr : in_data.advertised_hop;
    c.metric = (m1 > 9'd16) ? MetricInf : m1[4:0];
    c.now = in_data.now_seconds;
  end

  assign in_ready = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q[wr_ptr] <= c;
    end
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (cmd_valid && cmd_ready) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, in_valid && in_ready} - {1'b0, cmd_valid && cmd_ready};
    end
  end
endmodule

FILE: rtl/core/rrtu_back.sv
// back part: scans the table, applies the update and compacts on removal
// depends on rrtu_pkg
module rrtu_back import rrtu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SHFT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_SHRD = 3'd5;

  row_t mem [TableDepth];
  row_t rd_row;
  logic [2:0] state;
  cmd_t cur;
  logic [CntW-1:0] count, ptr;
  logic [IdxW-1:0] hit;
  logic wr_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  row_t wr_row;
  logic same;

  assign cmd_ready = (state == S_IDLE);
  assign same = (rd_row.origin == cur.neighbour);
  assign rd_addr = ptr[IdxW-1:0];

  always_ff @(posedge clk) begin
    rd_row <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = hit;
    wr_row = rd_row;
    if (state == S_CMP) begin
      if (ptr == count) begin
        wr_en = (cur.metric != MetricInf) && (count != CntW'(TableDepth));
        wr_addr = count[IdxW-1:0];
        wr_row = '{cur.prefix, cur.mask, cur.hop, cur.port, cur.metric, cur.now,
                   cur.neighbour};
      end else if (rd_row.prefix == cur.prefix && rd_row.mask == cur.mask) begin
        wr_addr = ptr[IdxW-1:0];
        if (same && cur.metric != MetricInf) begin
          wr_en = 1'b1;
          wr_row.metric = cur.metric; wr_row.hop = cur.hop;
          wr_row.port = cur.port; wr_row.stamp = cur.now;
        end else if (cur.metric < rd_row.metric && cur.metric != MetricInf) begin
          wr_en = 1'b1;
          wr_row.metric = cur.metric; wr_row.hop = cur.hop;
          wr_row.port = cur.port; wr_row.stamp = cur.now;
        end else if (same && !(cur.metric < rd_row.metric)) begin
          wr_en = 1'b1;
          wr_row.stamp = cur.now;
        end
      end
    end else if (state == S_SHFT) begin
      // row ptr has been read; move it down one place
      wr_en = 1'b1;
      wr_addr = ptr[IdxW-1:0] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd_valid) begin
          cur <= cmd;
          ptr <= '0;
          state <= S_READ;
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (ptr == count) begin
            out_data.entry_index <= '0;
            if (cur.metric == MetricInf) begin
              out_data.action <= ACT_IGNORED;
            end else if (count == CntW'(TableDepth)) begin
              out_data.action <= ACT_FULL;
            end else begin
              out_data.action <= ACT_INSERTED;
              out_data.entry_index <= 10'(count);
              count <= count + 1'b1;
            end
            out_data.entry_count <= 11'(count + ((cur.metric != MetricInf &&
                                     count != CntW'(TableDepth)) ? 1 : 0));
            state <= S_DONE;
            out_valid <= 1'b1;
          end else if (rd_row.prefix == cur.prefix && rd_row.mask == cur.mask) begin
            out_data.entry_index <= 10'(ptr);
            out_data.entry_count <= 11'(count);
            hit <= ptr[IdxW-1:0];
            if ((cur.metric < rd_row.metric) || same) begin
              if (cur.metric == MetricInf) begin
                out_data.action <= ACT_REMOVED;
                out_data.entry_count <= 11'(count - 1'b1);
                if (ptr + 1'b1 < count) begin
                  ptr <= ptr + 1'b1;
                  state <= S_SHRD;
                end else begin
                  count <= count - 1'b1;
                  state <= S_DONE;
                  out_valid <= 1'b1;
                end
              end else begin
                out_data.action <= ACT_UPDATED;
                state <= S_DONE;
                out_valid <= 1'b1;
              end
            end else begin
              out_data.action <= ACT_KEPT;
              state <= S_DONE;
              out_valid <= 1'b1;
            end
          end else begin
            ptr <= ptr + 1'b1;
            state <= S_READ;
          end
        end
        // wait for the registered read of row ptr
        S_SHRD: state <= S_SHFT;
        S_SHFT: begin
          if (ptr + 1'b1 < count) begin
            ptr <= ptr + 1'b1;
            state <= S_SHRD;
          end else begin
            count <= count - 1'b1;
            state <= S_DONE;
            out_valid <= 1'b1;
          end
        end
        S_DONE: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/rip_route_table_update.sv
// RIP route table update: each accepted route entry is saturated, matched
// against the table by a linear scan and applied as keep, update, remove
// (with compaction), insert, ignore or full; exactly one result per entry.
// the table is scanned one row at a time (one memory read port, registered
// read); when a removal compacts the table each later row is moved by a read,
// then a write one place down; a two-deep queue in front lets new entries be
// taken while the back end is busy. no clearing pass: only rows below the
// valid count are ever used.
// depends on rrtu_pkg, rrtu_front, rrtu_back
module rip_route_table_update import rrtu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);
  // queue between front and back
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  rrtu_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd
  );

  // scan, update and compaction engine; result held until transfer
  rrtu_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .out_data
  );
endmodule

FILE: rtl/core/rrtu_checker.sv
// port-level checks for the route table update block
// depends on rrtu_pkg and rip_route_table_update_defines.svh
`include "rip_route_table_update_defines.svh"
module rrtu_checker import rrtu_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  `RRTU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped")
  `RRTU_ASSERT(a_act_range, out_valid |-> out_data.action <= ACT_FULL, "bad action")
  `RRTU_ASSERT(a_count_range, out_valid |-> out_data.entry_count <= 11'(TableDepth), "bad count")
  `RRTU_ASSERT(a_ready_known, in_valid |-> !$isunknown(in_ready), "in_ready unknown")
  `RRTU_ASSERT_ALWAYS(a_rst_idle, rst |=> !out_valid, "valid after reset")
endmodule

bind rip_route_table_update rrtu_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

FILE: tb/sv/tb_rip_route_table_update.sv
// self-checking testbench for rip_route_table_update: directed table then random route entries
// depends on rrtu_pkg and the rip_route_table_update rtl
module tb_rip_route_table_update;
  import rrtu_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  rip_route_table_update u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // clock, 12 units per period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the route table
  logic [31:0] tbl_prefix [TableDepth];
  logic [31:0] tbl_mask   [TableDepth];
  logic [31:0] tbl_hop    [TableDepth];
  logic [1:0]  tbl_port   [TableDepth];
  logic [4:0]  tbl_metric [TableDepth];
  logic [31:0] tbl_stamp  [TableDepth];
  logic [31:0] tbl_origin [TableDepth];
  int          route_count;

  rsp_t   expected_rsp_q[$];
  int     error_count;
  int     transfers_in;
  int     transfers_out;
  int     full_seen;
  int     removed_seen;
  int     idle_cycles;
  logic   hold_off;
  logic   stim_done;

  // pool of prefixes used so random entries hit existing routes often
  logic [31:0] pool_prefix [16];
  logic [31:0] pool_mask   [16];
  logic [31:0] pool_nbr    [4];

  // applies one route entry to the shadow table, returns the expected result
  function automatic rsp_t apply_route(req_t r);
    rsp_t        res;
    logic [8:0]  m9;
    logic [4:0]  m;
    logic [31:0] hop;
    int          hit;
    logic        same_origin;
    m9  = {1'b0, r.advertised_metric} + 9'd1;
    m   = (m9 > 9'd16) ? MetricInf : m9[4:0];
    hop = (r.advertised_hop == 32'd0) ? r.neighbour_addr : r.advertised_hop;
    hit = -1;
    res.action      = ACT_IGNORED;
    res.entry_index = '0;
    for (int i = 0; i < route_count; i++) begin
      if (hit < 0 && tbl_prefix[i] == r.route_prefix && tbl_mask[i] == r.route_mask) begin
        hit = i;
      end
    end
    if (hit >= 0) begin
      same_origin     = (tbl_origin[hit] == r.neighbour_addr);
      res.entry_index = hit[9:0];
      res.action      = ACT_KEPT;
      if (same_origin) tbl_stamp[hit] = r.now_seconds;
      if (m < tbl_metric[hit] || same_origin) begin
        if (m >= MetricInf) begin
          // compact the table over the removed row
          for (int k = hit; k + 1 < route_count; k++) begin
            tbl_prefix[k] = tbl_prefix[k+1];
            tbl_mask[k]   = tbl_mask[k+1];
            tbl_hop[k]    = tbl_hop[k+1];
            tbl_port[k]   = tbl_port[k+1];
            tbl_metric[k] = tbl_metric[k+1];
            tbl_stamp[k]  = tbl_stamp[k+1];
            tbl_origin[k] = tbl_origin[k+1];
          end
          route_count--;
          res.action = ACT_REMOVED;
        end else begin
          tbl_metric[hit] = m;
          tbl_hop[hit]    = hop;
          tbl_port[hit]   = r.in_port;
          tbl_stamp[hit]  = r.now_seconds;
          res.action      = ACT_UPDATED;
        end
      end
    end else if (m < MetricInf) begin
      if (route_count < TableDepth) begin
        tbl_prefix[route_count] = r.route_prefix;
        tbl_mask[route_count]   = r.route_mask;
        tbl_hop[route_count]    = hop;
        tbl_port[route_count]   = r.in_port;
        tbl_metric[route_count] = m;
        tbl_stamp[route_count]  = r.now_seconds;
        tbl_origin[route_count] = r.neighbour_addr;
        res.entry_index         = route_count[9:0];
        route_count++;
        res.action = ACT_INSERTED;
      end else begin
        res.action = ACT_FULL;
      end
    end
    res.entry_count = route_count[10:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", transfers_out, what, got, want);
    error_count++;
  endtask

  function automatic req_t make_route(logic [1:0] p, logic [31:0] nbr, logic [31:0] pfx,
                                      logic [31:0] msk, logic [31:0] hop, logic [7:0] met,
                                      logic [31:0] now);
    req_t r;
    r.in_port = p; r.neighbour_addr = nbr; r.route_prefix = pfx; r.route_mask = msk;
    r.advertised_hop = hop; r.advertised_metric = met; r.now_seconds = now;
    return r;
  endfunction

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  // mostly short gaps, sometimes a long one, sometimes none
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random entry: mostly aimed at the prefix pool with a known neighbour
  function automatic req_t random_route();
    req_t r;
    int   sel;
    int   pick;
    sel  = $urandom_range(0, 99);
    pick = $urandom_range(0, 15);
    r = make_route(2'($urandom_range(0, 3)), pool_nbr[$urandom_range(0, 3)],
                   pool_prefix[pick], pool_mask[pick], 32'd0, 8'($urandom_range(0, 15)),
                   rand32());
    if ($urandom_range(0, 1)) r.advertised_hop = rand32();
    if (sel < 12) r.advertised_metric = 8'($urandom_range(15, 255));
    else if (sel < 20) begin
      r.neighbour_addr = rand32();
      r.route_prefix   = rand32();
      r.route_mask     = rand32();
    end
    return r;
  endfunction

  // send one transfer, valid held until accepted
  task automatic send_route(input req_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_rsp_q.push_back(apply_route(r));
    transfers_in++;
  endtask

  task automatic send_with_gap(input req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    send_route(r);
  endtask

  // directed rows: entry plus optional typed-in expectation
  typedef struct {
    req_t       r;
    logic       has_exp;
    logic [2:0] act;
    logic [9:0] idx;
    logic [10:0] cnt;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(req_t r, logic has_exp, logic [2:0] act,
                                  logic [9:0] idx, logic [10:0] cnt);
    dir_row_t d;
    d.r = r; d.has_exp = has_exp; d.act = act; d.idx = idx; d.cnt = cnt;
    dir_rows.push_back(d);
  endfunction

  // sender
  initial begin
    req_t r;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    stim_done = 1'b0;
    route_count = 0;
    error_count = 0;
    transfers_in = 0;
    full_seen = 0;
    removed_seen = 0;
    for (int i = 0; i < 16; i++) begin
      pool_prefix[i] = rand32();
      pool_mask[i]   = (i == 0) ? 32'hFFFF_FFFF : rand32();
    end
    pool_nbr[0] = 32'hFFFF_FFFF;
    for (int i = 1; i < 4; i++) pool_nbr[i] = rand32();

    // first insert, all fields but the metric at their top extreme; metric 14 gives 15
    add_row(make_route(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       8'd14, 32'hFFFF_FFFF), 1'b1, ACT_INSERTED, 10'd0, 11'd1);
    // unknown unreachable route is ignored
    add_row(make_route(2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd255, 32'd0),
            1'b1, ACT_IGNORED, 10'd0, 11'd1);
    add_row(make_route(2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd15, 32'd0),
            1'b1, ACT_IGNORED, 10'd0, 11'd1);
    // zero next hop takes the neighbour, bottom extremes
    add_row(make_route(2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0),
            1'b1, ACT_INSERTED, 10'd1, 11'd2);
    // other neighbour, worse metric: kept
    add_row(make_route(2'd1, 32'h0A00_0001, 32'd0, 32'd0, 32'h0A00_00FE, 8'd5, 32'd7),
            1'b1, ACT_KEPT, 10'd1, 11'd2);
    // same origin refresh with worse metric still updates
    add_row(make_route(2'd2, 32'd0, 32'd0, 32'd0, 32'd0, 8'd9, 32'd100),
            1'b1, ACT_UPDATED, 10'd1, 11'd2);
    // other neighbour with better metric updates, origin stays
    add_row(make_route(2'd1, 32'h0A00_0001, 32'd0, 32'd0, 32'd0, 8'd1, 32'd200),
            1'b1, ACT_UPDATED, 10'd1, 11'd2);
    // other neighbour advertising unreachable: kept
    add_row(make_route(2'd1, 32'h0A00_0001, 32'd0, 32'd0, 32'd0, 8'd200, 32'd300),
            1'b1, ACT_KEPT, 10'd1, 11'd2);
    // a few more routes so removal compacts across rows
    add_row(make_route(2'd2, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                       8'd3, 32'h5555_5555), 1'b1, ACT_INSERTED, 10'd2, 11'd3);
    add_row(make_route(2'd1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                       8'd7, 32'hAAAA_AAAA), 1'b1, ACT_INSERTED, 10'd3, 11'd4);
    // same prefix, other mask is a separate route
    add_row(make_route(2'd0, 32'd9, 32'hAAAA_AAAA, 32'hFFFF_0000, 32'd0, 8'd2, 32'd1),
            1'b1, ACT_INSERTED, 10'd4, 11'd5);
    // origin withdraws with metric 16: removed and table compacted
    add_row(make_route(2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd15, 32'd5),
            1'b1, ACT_REMOVED, 10'd1, 11'd4);
    // rows after the removed one have moved down
    add_row(make_route(2'd3, 32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAA, 32'd0, 8'd0,
                       32'd9), 1'b1, ACT_UPDATED, 10'd2, 11'd4);
    add_row(make_route(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 8'd255,
                       32'd3), 1'b1, ACT_REMOVED, 10'd0, 11'd3);
    add_row(make_route(2'd1, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'd0, 8'd14,
                       32'd11), 1'b0, ACT_KEPT, 10'd0, 11'd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        rsp_t want;
        rsp_t pred;
        req_t tmp;
        tmp = dir_rows[i].r;
        send_with_gap(tmp);
        pred = expected_rsp_q[$];
        want.action = dir_rows[i].act;
        want.entry_index = dir_rows[i].idx;
        want.entry_count = dir_rows[i].cnt;
        if (pred != want) begin
          $display("directed row %0d disagrees with predictor", i);
          error_count++;
          expected_rsp_q[$] = want;
        end
      end else begin
        send_with_gap(dir_rows[i].r);
      end
    end

    // random part, well-formed hits on a small pool plus noise
    for (int n = 0; n < 540; n++) begin
      r = random_route();
      send_with_gap(r);
    end

    // a few fresh routes with zero next hop
    for (int n = 0; n < 6; n++) begin
      r = make_route(2'($urandom_range(0, 3)), rand32(), rand32(), rand32(), 32'd0,
                     8'($urandom_range(0, 14)), rand32());
      send_with_gap(r);
    end
    // withdraw the pooled routes
    for (int n = 0; n < 16; n++) begin
      r = make_route(2'd0, pool_nbr[n % 4], pool_prefix[n], pool_mask[n], 32'd0,
                     8'd255, 32'd0);
      send_with_gap(r);
    end
    in_valid  <= 1'b0;
    stim_done <= 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int g;
    int stretch;
    out_ready = 1'b0;
    hold_off  = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (transfers_in >= 40 && !hold_off) begin
        // long hold-off while the sender keeps offering
        hold_off  <= 1'b1;
        out_ready <= 1'b0;
        stretch = 0;
        while (stretch < 300) begin
          @(posedge clk);
          stretch++;
        end
        out_ready <= 1'b1;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      transfers_out++;
      if (expected_rsp_q.size() == 0) begin
        $display("result %0d arrived with nothing expected", transfers_out);
        error_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_data.action != want.action)
          report_mismatch("action", out_data.action, want.action);
        if (out_data.entry_index != want.entry_index)
          report_mismatch("entry_index", out_data.entry_index, want.entry_index);
        if (out_data.entry_count != want.entry_count)
          report_mismatch("entry_count", out_data.entry_count, want.entry_count);
        if (want.action == ACT_FULL) full_seen++;
        if (want.action == ACT_REMOVED) removed_seen++;
      end
    end
  end

  // watchdog on cycles without any transfer; covers a full-table scan and a long stall
  initial transfers_out = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 40000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // end of run
  initial begin
    idle_cycles = 0;
    wait (stim_done === 1'b1);
    wait (expected_rsp_q.size() == 0);
    repeat (3500) @(posedge clk);
    $display("covered %0d route entries, %0d results, %0d removals, %0d table-full drops",
             transfers_in, transfers_out, removed_seen, full_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rrtu_pkg.sv
rtl/core/rrtu_front.sv
rtl/core/rrtu_back.sv
rtl/core/rip_route_table_update.sv
rtl/core/rrtu_checker.sv
tb/sv/tb_rip_route_table_update.sv
